// ----- rtl/core/staggered_trapezoid_profile_generator_unit_assert.svh -----
// Assertion helpers for the profile generator. Each macro expects clk_i and
// rst_ni in the scope where it is used.
`ifndef STAGGERED_TRAPEZOID_PROFILE_GENERATOR_UNIT_ASSERT_SVH
`define STAGGERED_TRAPEZOID_PROFILE_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define STPG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STPG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/stpg_pkg.sv -----
`default_nettype none
package stpg_pkg;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t RegTimeStep   = 3'd0;
  localparam reg_idx_t RegAccelRatio = 3'd1;
  localparam reg_idx_t RegRoundTrips = 3'd2;
  localparam reg_idx_t RegSpeedStep  = 3'd3;
  localparam reg_idx_t RegNominal    = 3'd4;

  localparam logic [15:0] TimeStepRst   = 16'd328;
  localparam logic [14:0] AccelRatioRst = 15'd6554;
  localparam logic [3:0]  RoundTripsRst = 4'd8;
  localparam logic [15:0] SpeedStepRst  = 16'd13107;
  localparam logic [23:0] NominalRst    = 24'd78643;

  // Products saturate at 2^40.
  localparam logic [40:0] MqCap  = 41'h100_0000_0000;
  localparam logic [31:0] SatMax = 32'h7FFF_FFFF;

  localparam int unsigned TdataInW  = 72;
  localparam int unsigned TdataOutW = 104;

  typedef enum logic [1:0] {
    PhRamp,
    PhCruise,
    PhBrake
  } phase_e;

  function automatic logic [31:0] sat32(input logic signed [45:0] v);
    logic [31:0] r;
    if (v > 46'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -46'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/stpg_ram.sv -----
`default_nettype none
module stpg_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/core/staggered_trapezoid_profile_generator_unit.sv -----
`default_nettype none
// Channel   Dir  Payload (tdata low bit up)                          Side band
// s_axis    in   joint_sel[2:0], limit_low, limit_high               tuser: op
// m_axis    out  joint_id[2:0], position, velocity, acceleration     tlast, tuser: done_res
// apb       in   time_step, accel_ratio, round_trips, speed_step, nominal_time at 4*i
//
// A tick computes the joints in turn: each joint runs six fixed-point products
// through one shared multiplier, split into the S_MA and S_MB states.
// A load, and a tick that ends a round trip with trips left, add a retime that
// runs the one-bit-per-cycle 64-step divider.
// Reset clears all control state; the limit memory holds no reset value.
// A stalled result waits in the output register while the next item is taken.
`include "staggered_trapezoid_profile_generator_unit_assert.svh"
module staggered_trapezoid_profile_generator_unit #(
  parameter int unsigned JOINTS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // tdata: joint_sel[2:0], limit_low[34:3], limit_high[66:35], zero pad
  input  wire logic [stpg_pkg::TdataInW-1:0]  s_axis_tdata,
  // tuser: op
  input  wire logic                           s_axis_tuser,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: joint_id[2:0], position[34:3], velocity[66:35],
  // acceleration[98:67], zero pad
  output logic [stpg_pkg::TdataOutW-1:0]      m_axis_tdata,
  // tuser: done_res
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [4:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);
  import stpg_pkg::*;

  localparam int unsigned AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  // The joint offset is cycle/JOINTS, taken as a rounded-up reciprocal product
  // that is exact for every 32-bit cycle time.
  localparam int unsigned OffShift = 32 + $clog2(JOINTS);
  localparam logic [32:0] OffRecip =
    33'(((65'd1 << OffShift) + 65'(JOINTS) - 65'd1) / 65'(JOINTS));

  localparam logic [4:0] S_IDLE = 5'd0,  S_RT0  = 5'd1,  S_RT1  = 5'd2,  S_RT2  = 5'd3;
  localparam logic [4:0] S_RT2B = 5'd4,  S_RT3  = 5'd5,  S_RT4  = 5'd6,  S_RT5  = 5'd7;
  localparam logic [4:0] S_RT6  = 5'd8,  S_RT7  = 5'd9,  S_RT8  = 5'd10, S_RT8B = 5'd11;
  localparam logic [4:0] S_RT9  = 5'd12, S_RT9B = 5'd13, S_RT10 = 5'd14, S_DIV  = 5'd15;
  localparam logic [4:0] S_TLD  = 5'd16, S_TPH  = 5'd17, S_MA   = 5'd18, S_MB   = 5'd19;
  localparam logic [4:0] S_TOUT = 5'd20, S_TEND = 5'd21, S_DONE = 5'd22;

  // Configuration.
  logic [15:0] ts_q, ts_d;
  logic [14:0] ratio_q, ratio_d;
  logic [3:0]  trips_q, trips_d;
  logic [15:0] sstep_q, sstep_d;
  logic [23:0] nom_q, nom_d;

  // Schedule state.
  logic [4:0]  state_q, state_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic        rev_q, rev_d;
  logic [3:0]  tc_q, tc_d;
  logic        fin_q, fin_d;
  logic        timed_q, timed_d;
  logic [31:0] cycle_q, cycle_d;
  logic [31:0] ramp_q, ramp_d;
  logic [31:0] cruise_q, cruise_d;
  logic [31:0] off_q, off_d;

  // Retime datapath.
  logic [18:0] s_q, s_d;
  logic [32:0] dl_q, dl_d;
  logic [30:0] pk_w_q, pk_w_d;

  // Divider.
  logic [63:0] div_num_q, div_num_d;
  logic [39:0] div_den_q, div_den_d;
  logic [39:0] div_rem_q, div_rem_d;
  logic [63:0] div_quo_q, div_quo_d;
  logic [5:0]  div_cnt_q, div_cnt_d;
  logic [4:0]  div_ret_q, div_ret_d;

  // Tick datapath.
  logic [AW-1:0] j_q, j_d;
  logic [36:0]   sh_q, sh_d;
  logic [31:0]   a_q, a_d;
  logic [31:0]   pk_q, pk_d;
  logic [31:0]   q0_q, q0_d;
  logic [31:0]   t_q, t_d;
  logic [31:0]   x_q, x_d;
  logic [31:0]   y_q, y_d;
  phase_e        ph_q, ph_d;
  logic [2:0]    k_q, k_d;
  logic [56:0]   hi_q, hi_d;
  logic [47:0]   lo_q, lo_d;
  logic [40:0]   m_q [6];
  logic [40:0]   m_d [6];

  // Output register.
  logic                 ov_q, ov_d;
  logic [TdataOutW-1:0] od_q, od_d;
  logic                 olast_q, olast_d;
  logic                 ouser_q, ouser_d;

  // Memories.
  logic          lim_we;
  logic [AW-1:0] lim_waddr;
  logic [63:0]   lim_rdata;
  logic          par_we;
  logic [63:0]   par_wdata;
  logic [63:0]   par_rdata;

  stpg_ram #(.WIDTH(64), .DEPTH(JOINTS)) u_lim_ram (
    .clk_i   (clk_i),
    .we_i    (lim_we),
    .waddr_i (lim_waddr),
    .wdata_i ({s_axis_tdata[66:35], s_axis_tdata[34:3]}),
    .raddr_i (j_d),
    .rdata_o (lim_rdata)
  );

  stpg_ram #(.WIDTH(64), .DEPTH(JOINTS)) u_par_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (j_q),
    .wdata_i (par_wdata),
    .raddr_i (j_d),
    .rdata_o (par_rdata)
  );

  // APB.
  logic     cfg_we;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    unique case (cfg_idx)
      RegTimeStep:   prdata = {16'b0, ts_q};
      RegAccelRatio: prdata = {17'b0, ratio_q};
      RegRoundTrips: prdata = {28'b0, trips_q};
      RegSpeedStep:  prdata = {16'b0, sstep_q};
      RegNominal:    prdata = {8'b0, nom_q};
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    ts_d    = ts_q;
    ratio_d = ratio_q;
    trips_d = trips_q;
    sstep_d = sstep_q;
    nom_d   = nom_q;
    if (cfg_we) begin
      unique case (cfg_idx)
        RegTimeStep:   ts_d    = pwdata[15:0];
        RegAccelRatio: ratio_d = pwdata[14:0];
        RegRoundTrips: trips_d = pwdata[3:0];
        RegSpeedStep:  sstep_d = pwdata[15:0];
        RegNominal:    nom_d   = pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Handshakes.
  logic in_acc;
  logic out_free;
  logic j_last;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ov_q || m_axis_tready;
  assign j_last        = (j_q == AW'(JOINTS - 1));

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = ouser_q;

  // Divider step: one quotient bit per cycle.
  logic [40:0] div_sh;
  logic        div_ge;
  logic [40:0] div_sub;

  assign div_sh  = {div_rem_q, div_num_q[63]};
  assign div_ge  = (div_sh >= {1'b0, div_den_q});
  assign div_sub = div_sh - {1'b0, div_den_q};

  // Shared product m(x, y) = floor(min(x, cap) * y / 2^16), capped.
  logic [40:0] mop_a;
  logic [31:0] mop_b;
  logic [40:0] mop_ac;
  logic [57:0] mq_sum;
  logic [40:0] mq_res;

  always_comb begin
    unique case (k_q)
      3'd0:    begin mop_a = {9'b0, a_q};  mop_b = ramp_q; end
      3'd1:    begin mop_a = m_q[0];       mop_b = ramp_q; end
      3'd2:    begin mop_a = {9'b0, a_q};  mop_b = x_q;    end
      3'd3:    begin mop_a = m_q[2];       mop_b = x_q;    end
      3'd4:    begin mop_a = {9'b0, pk_q}; mop_b = y_q;    end
      default: begin mop_a = {9'b0, pk_q}; mop_b = x_q;    end
    endcase
  end

  assign mop_ac = (mop_a > MqCap) ? MqCap : mop_a;
  assign mq_sum = {1'b0, hi_q} + {26'b0, lo_q[47:16]};
  assign mq_res = (mq_sum > {17'b0, MqCap}) ? MqCap : mq_sum[40:0];

  // Per-joint time and phase.
  logic [36:0] el_ext;
  logic [36:0] t_raw;
  logic [31:0] t_cl;
  logic [32:0] rc_sum;

  assign el_ext = {5'b0, elapsed_q};
  assign t_raw  = (el_ext > sh_q) ? (el_ext - sh_q) : '0;
  assign t_cl   = (t_raw > {5'b0, cycle_q}) ? cycle_q : t_raw[31:0];
  assign rc_sum = {1'b0, ramp_q} + {1'b0, cruise_q};

  // Result arithmetic.
  logic signed [45:0] as_s, pk_s, m2_s, m3h_s, d1_s, m4_s, m5_s;
  logic signed [45:0] v_raw, p_raw, acc_raw;
  logic signed [45:0] v_fin, p_fin, acc_fin, pos_fin;

  assign as_s  = $signed({14'b0, a_q});
  assign pk_s  = $signed({14'b0, pk_q});
  assign m2_s  = $signed({5'b0, m_q[2]});
  assign m3h_s = $signed({6'b0, m_q[3][40:1]});
  assign d1_s  = $signed({6'b0, m_q[1][40:1]});
  assign m4_s  = $signed({5'b0, m_q[4]});
  assign m5_s  = $signed({5'b0, m_q[5]});

  always_comb begin
    unique case (ph_q)
      PhRamp: begin
        v_raw = m2_s; p_raw = m3h_s; acc_raw = as_s;
      end
      PhCruise: begin
        v_raw = pk_s; p_raw = d1_s + m4_s; acc_raw = '0;
      end
      default: begin
        v_raw   = pk_s - m2_s;
        p_raw   = d1_s + m4_s + m5_s - m3h_s;
        acc_raw = -as_s;
      end
    endcase
  end

  assign v_fin   = rev_q ? -v_raw : v_raw;
  assign p_fin   = rev_q ? -p_raw : p_raw;
  assign acc_fin = rev_q ? -acc_raw : acc_raw;
  assign pos_fin = $signed({{14{q0_q[31]}}, q0_q}) + p_fin;

  // Retime arithmetic.
  logic [35:0] den_w;
  logic [46:0] rmp_w;
  logic [32:0] dl_w;
  logic [51:0] prod_w;
  logic [32:0] full_w;
  logic [32:0] ne_w;
  logic [31:0] ne_s;
  logic [3:0]  tc_inc;
  logic [64:0] off_prod;
  logic [31:0] off_w;

  assign den_w  = s_q * (17'h1_0000 - {2'b0, ratio_q});
  assign rmp_w  = cycle_q * ratio_q;
  assign dl_w   = ($signed(lim_rdata[63:32]) >= $signed(lim_rdata[31:0]))
                ? ({lim_rdata[63], lim_rdata[63:32]} - {lim_rdata[31], lim_rdata[31:0]})
                : ({lim_rdata[31], lim_rdata[31:0]} - {lim_rdata[63], lim_rdata[63:32]});
  assign prod_w = s_q * dl_q;
  assign full_w = {cycle_q, 1'b0} - {1'b0, off_q};
  assign ne_w   = {1'b0, elapsed_q} + {17'b0, ts_q};
  assign ne_s   = ne_w[32] ? 32'hFFFF_FFFF : ne_w[31:0];
  assign tc_inc = (tc_q < 4'd15) ? (tc_q + 4'd1) : tc_q;
  assign off_prod = cycle_q * OffRecip;
  assign off_w    = 32'(off_prod >> OffShift);

  // Ramp rate in the upper word, peak velocity in the lower word.
  assign par_wdata = {1'b0, div_quo_q[30:0], 1'b0, pk_w_q};

  always_comb begin
    state_d   = state_q;
    elapsed_d = elapsed_q;
    rev_d     = rev_q;
    tc_d      = tc_q;
    fin_d     = fin_q;
    timed_d   = timed_q;
    cycle_d   = cycle_q;
    ramp_d    = ramp_q;
    cruise_d  = cruise_q;
    off_d     = off_q;
    s_d       = s_q;
    dl_d      = dl_q;
    pk_w_d    = pk_w_q;
    div_num_d = div_num_q;
    div_den_d = div_den_q;
    div_rem_d = div_rem_q;
    div_quo_d = div_quo_q;
    div_cnt_d = div_cnt_q;
    div_ret_d = div_ret_q;
    j_d       = j_q;
    sh_d      = sh_q;
    a_d       = a_q;
    pk_d      = pk_q;
    q0_d      = q0_q;
    t_d       = t_q;
    x_d       = x_q;
    y_d       = y_q;
    ph_d      = ph_q;
    k_d       = k_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    m_d       = m_q;
    ov_d      = ov_q && !m_axis_tready;
    od_d      = od_q;
    olast_d   = olast_q;
    ouser_d   = ouser_q;
    lim_we    = 1'b0;
    lim_waddr = AW'(s_axis_tdata[2:0]);
    par_we    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!s_axis_tuser) begin
            lim_we    = ({29'b0, s_axis_tdata[2:0]} < JOINTS);
            elapsed_d = '0;
            rev_d     = 1'b0;
            tc_d      = '0;
            fin_d     = 1'b0;
            state_d   = S_RT0;
          end else if (fin_q || (tc_q >= trips_q)) begin
            fin_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            j_d     = '0;
            sh_d    = '0;
            state_d = S_TLD;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          od_d    = '0;
          olast_d = 1'b1;
          ouser_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RT0: begin
        s_d     = sstep_q * ({1'b0, tc_q[3:1]} + 4'd1);
        state_d = S_RT1;
      end
      S_RT1: begin
        div_den_d = {4'b0, den_w};
        state_d   = S_RT2;
      end
      S_RT2: begin
        if (div_den_q == '0) begin
          cycle_d = 32'hFFFF_FFFF;
          state_d = S_RT3;
        end else begin
          div_num_d = {8'b0, nom_q, 32'b0};
          div_rem_d = '0;
          div_cnt_d = '0;
          div_ret_d = S_RT2B;
          state_d   = S_DIV;
        end
      end
      S_RT2B: begin
        cycle_d = (div_quo_q[63:32] != '0) ? 32'hFFFF_FFFF : div_quo_q[31:0];
        state_d = S_RT3;
      end
      S_RT3: begin
        ramp_d  = {1'b0, rmp_w[46:16]};
        state_d = S_RT4;
      end
      S_RT4: begin
        cruise_d = cycle_q - {ramp_q[30:0], 1'b0};
        off_d    = off_w;
        state_d  = S_RT5;
      end
      S_RT5: begin
        j_d     = '0;
        state_d = S_RT6;
      end
      S_RT6: begin
        dl_d    = dl_w;
        state_d = S_RT7;
      end
      S_RT7: begin
        div_num_d = {12'b0, prod_w};
        div_den_d = {16'b0, nom_q};
        state_d   = S_RT8;
      end
      S_RT8: begin
        if (nom_q == '0) begin
          pk_w_d  = SatMax[30:0];
          state_d = S_RT9;
        end else begin
          div_rem_d = '0;
          div_cnt_d = '0;
          div_ret_d = S_RT8B;
          state_d   = S_DIV;
        end
      end
      S_RT8B: begin
        pk_w_d  = (div_quo_q[63:31] != '0) ? SatMax[30:0] : div_quo_q[30:0];
        state_d = S_RT9;
      end
      S_RT9: begin
        if (ramp_q == '0) begin
          pk_w_d  = pk_w_q;
          state_d = S_RT10;
          div_quo_d = {33'b0, SatMax[30:0]};
        end else begin
          div_num_d = {17'b0, pk_w_q, 16'b0};
          div_den_d = {8'b0, ramp_q};
          div_rem_d = '0;
          div_cnt_d = '0;
          div_ret_d = S_RT9B;
          state_d   = S_DIV;
        end
      end
      S_RT9B: begin
        if (div_quo_q[63:31] != '0) begin
          div_quo_d = {33'b0, SatMax[30:0]};
        end
        state_d = S_RT10;
      end
      S_RT10: begin
        par_we = 1'b1;
        if (j_last) begin
          timed_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          j_d     = j_q + AW'(1);
          state_d = S_RT6;
        end
      end
      S_DIV: begin
        div_num_d = {div_num_q[62:0], 1'b0};
        div_rem_d = div_ge ? div_sub[39:0] : div_sh[39:0];
        div_quo_d = {div_quo_q[62:0], div_ge};
        div_cnt_d = div_cnt_q + 6'd1;
        if (div_cnt_q == 6'd63) begin
          state_d = div_ret_q;
        end
      end
      S_TLD: begin
        a_d     = timed_q ? par_rdata[63:32] : '0;
        pk_d    = timed_q ? par_rdata[31:0] : '0;
        q0_d    = rev_q ? lim_rdata[63:32] : lim_rdata[31:0];
        t_d     = t_cl;
        state_d = S_TPH;
      end
      S_TPH: begin
        if (t_q <= ramp_q) begin
          ph_d = PhRamp;
          x_d  = t_q;
          y_d  = cruise_q;
        end else if ({1'b0, t_q} <= rc_sum) begin
          ph_d = PhCruise;
          x_d  = t_q;
          y_d  = t_q - ramp_q;
        end else begin
          ph_d = PhBrake;
          x_d  = t_q - ramp_q - cruise_q;
          y_d  = cruise_q;
        end
        k_d     = '0;
        state_d = S_MA;
      end
      S_MA: begin
        hi_d    = mop_ac[40:16] * mop_b;
        lo_d    = mop_ac[15:0] * mop_b;
        state_d = S_MB;
      end
      S_MB: begin
        m_d[k_q] = mq_res;
        k_d      = k_q + 3'd1;
        state_d  = (k_q == 3'd5) ? S_TOUT : S_MA;
      end
      S_TOUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          od_d    = {5'b0, sat32(acc_fin), sat32(v_fin), sat32(pos_fin), 3'(j_q)};
          olast_d = j_last;
          ouser_d = 1'b0;
          if (j_last) begin
            state_d = S_TEND;
          end else begin
            j_d     = j_q + AW'(1);
            sh_d    = sh_q + {5'b0, off_q};
            state_d = S_TLD;
          end
        end
      end
      S_TEND: begin
        state_d = S_IDLE;
        if ({1'b0, ne_s} > full_w) begin
          elapsed_d = '0;
          if (rev_q) begin
            rev_d = 1'b0;
            tc_d  = tc_inc;
            if (tc_inc >= trips_q) begin
              fin_d = 1'b1;
            end else begin
              state_d = S_RT0;
            end
          end else begin
            rev_d = 1'b1;
          end
        end else begin
          elapsed_d = ne_s;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q      <= TimeStepRst;
      ratio_q   <= AccelRatioRst;
      trips_q   <= RoundTripsRst;
      sstep_q   <= SpeedStepRst;
      nom_q     <= NominalRst;
      state_q   <= S_IDLE;
      elapsed_q <= '0;
      rev_q     <= 1'b0;
      tc_q      <= '0;
      fin_q     <= 1'b0;
      timed_q   <= 1'b0;
      cycle_q   <= '0;
      ramp_q    <= '0;
      cruise_q  <= '0;
      off_q     <= '0;
      div_ret_q <= S_IDLE;
      div_cnt_q <= '0;
      j_q       <= '0;
      k_q       <= '0;
      ov_q      <= 1'b0;
    end else begin
      ts_q      <= ts_d;
      ratio_q   <= ratio_d;
      trips_q   <= trips_d;
      sstep_q   <= sstep_d;
      nom_q     <= nom_d;
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
      rev_q     <= rev_d;
      tc_q      <= tc_d;
      fin_q     <= fin_d;
      timed_q   <= timed_d;
      cycle_q   <= cycle_d;
      ramp_q    <= ramp_d;
      cruise_q  <= cruise_d;
      off_q     <= off_d;
      div_ret_q <= div_ret_d;
      div_cnt_q <= div_cnt_d;
      j_q       <= j_d;
      k_q       <= k_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q       <= s_d;
    dl_q      <= dl_d;
    pk_w_q    <= pk_w_d;
    div_num_q <= div_num_d;
    div_den_q <= div_den_d;
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
    sh_q      <= sh_d;
    a_q       <= a_d;
    pk_q      <= pk_d;
    q0_q      <= q0_d;
    t_q       <= t_d;
    x_q       <= x_d;
    y_q       <= y_d;
    ph_q      <= ph_d;
    hi_q      <= hi_d;
    lo_q      <= lo_d;
    m_q       <= m_d;
    od_q      <= od_d;
    olast_q   <= olast_d;
    ouser_q   <= ouser_d;
  end

  `STPG_ASSERT_IMP(a_done_shape, m_axis_tvalid && m_axis_tuser,
                   m_axis_tlast && (m_axis_tdata == '0), "done result not alone or not zero")
  `STPG_ASSERT_NXT(a_load_busy, s_axis_tvalid && s_axis_tready && !s_axis_tuser,
                   !s_axis_tready, "load transfer did not start a retime")
  `STPG_ASSERT_IMP(a_div_nonzero, state_q == S_DIV, div_den_q != '0,
                   "divider started with a zero divisor")

endmodule
`default_nettype wire
